// ----- rtl/core/rre_pkg.sv -----
// ----------------------------------------------------------------------------
// rre_pkg
// Shared widths, command codes and error codes of the fraction evaluator.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 2 * WORD_W;

  typedef logic [2:0] cmd_t;
  typedef logic [1:0] err_t;

  localparam cmd_t CMD_PUSH = 3'd0;
  localparam cmd_t CMD_ADD  = 3'd1;
  localparam cmd_t CMD_SUB  = 3'd2;
  localparam cmd_t CMD_MUL  = 3'd3;
  localparam cmd_t CMD_DIV  = 3'd4;
  localparam cmd_t CMD_END  = 3'd5;

  localparam err_t ERR_NONE  = 2'd0;
  localparam err_t ERR_UNDER = 2'd1;
  localparam err_t ERR_OVER  = 2'd2;
  localparam err_t ERR_ZERO  = 2'd3;

endpackage

// ----- rtl/core/rpn_rational_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// rpn_rational_evaluator_top
// Postfix evaluator over 32-bit fractions with a small stack in RAM.
// ----------------------------------------------------------------------------
// An operator makes two stack reads through the registered RAM port, then two
// or three products from the one shared 32x32 multiplier, then the write-back.
// An end token runs its divisions on the shared bit-serial divider: one for the
// quotient and remainder, one per Euclid step, two for the reduction, plus the
// output handoff; an end with an error pending goes straight to the handoff.
// The block takes no beat while a token is in work. Products, sums and
// quotients wrap at 32 bits.
module rpn_rational_evaluator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] operand_numerator, [63:32] operand_denominator
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] integer_part, [63:32] fraction_numerator,
                                 // [95:64] fraction_denominator
  output logic [2:0]  m_tuser    // [0] has_fraction, [2:1] error_code
);
  import rre_pkg::*;

  typedef enum logic [3:0] {
    IDLE, OP_HI, OP_LO, OP_MUL, OP_WR,
    E_LD, E_Q, E_G, E_GW, E_R1W, E_R2, E_R2W, FIN
  } state_t;

  state_t             state;
  logic [SP_W-1:0]    sp;
  err_t               sticky;
  cmd_t               cmd_q;
  logic [1:0]         step;
  logic [WORD_W-1:0]  tn, td, ln, ld, rn, rd, prod;
  logic [WORD_W-1:0]  a_r, b_r, d_r, r_r;
  logic [WORD_W-1:0]  res_ip, res_fn, res_fd;
  err_t               res_err;

  logic               accept;
  cmd_t               cmd;
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [WORD_W-1:0]  ma, mb;
  logic [2*WORD_W-1:0] mfull;
  logic               div_start, div_done;
  logic [WORD_W-1:0]  div_a, div_b, div_q, div_r;
  logic [SP_W-1:0]    sp_m1, sp_m2;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign cmd      = s_tuser;
  assign sp_m1    = sp - SP_W'(1);
  assign sp_m2    = sp - SP_W'(2);

  rre_ram #(.WIDTH(ENTRY_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rre_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // stack port: push writes at the accept edge, operators write back the lower entry
  always_comb begin
    we    = 1'b0;
    waddr = sp[ADDR_W-1:0];
    wdata = s_tdata;
    raddr = (state == OP_HI) ? sp_m2[ADDR_W-1:0] : sp_m1[ADDR_W-1:0];
    if (accept && cmd == CMD_PUSH && sp < SP_W'(STACK_DEPTH)) begin
      we = 1'b1;
    end else if (state == OP_WR) begin
      we    = 1'b1;
      waddr = sp_m2[ADDR_W-1:0];
      wdata = {rd, rn};
    end
  end

  // shared multiplier operands
  always_comb begin
    ma = ld;
    mb = td;
    case (step)
      2'd0: begin
        ma = ln;
        mb = (cmd_q == CMD_MUL) ? tn : td;
      end
      2'd1: begin
        ma = ld;
        mb = (cmd_q == CMD_MUL) ? td : tn;
      end
      default: begin
        ma = ld;
        mb = td;
      end
    endcase
  end

  assign mfull = ma * mb;

  always_comb begin
    div_start = 1'b0;
    div_a     = a_r;
    div_b     = b_r;
    case (state)
      E_LD: begin
        div_start = (rdata[ENTRY_W-1:WORD_W] != '0);
        div_a     = rdata[WORD_W-1:0];
        div_b     = rdata[ENTRY_W-1:WORD_W];
      end
      E_G: begin
        div_start = 1'b1;
        if ($signed(b_r) > 0) begin
          div_a = a_r;
          div_b = b_r;
        end else begin
          div_a = r_r;
          div_b = a_r;
        end
      end
      E_R2: begin
        div_start = 1'b1;
        div_a     = d_r;
        div_b     = a_r;
      end
      default: div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      sp       <= '0;
      sticky   <= ERR_NONE;
      m_tvalid <= 1'b0;
    end else begin
      // the final state decides the output valid on its own
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            cmd_q <= cmd;
            case (cmd)
              CMD_PUSH: begin
                if (sp < SP_W'(STACK_DEPTH)) begin
                  sp <= sp + SP_W'(1);
                end else if (sticky == ERR_NONE) begin
                  sticky <= ERR_OVER;
                end
              end
              CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                if (sp < SP_W'(2)) begin
                  if (sticky == ERR_NONE) begin
                    sticky <= ERR_UNDER;
                  end
                end else begin
                  state <= OP_HI;
                end
              end
              CMD_END: begin
                sp     <= '0;
                sticky <= ERR_NONE;
                res_ip <= '0;
                res_fn <= '0;
                res_fd <= '0;
                if (sticky != ERR_NONE) begin
                  res_err <= sticky;
                  state   <= FIN;
                end else if (sp == '0) begin
                  res_err <= ERR_UNDER;
                  state   <= FIN;
                end else begin
                  state <= E_LD;
                end
              end
              default: state <= IDLE;
            endcase
          end
        end
        OP_HI: begin
          tn    <= rdata[WORD_W-1:0];
          td    <= rdata[ENTRY_W-1:WORD_W];
          state <= OP_LO;
        end
        OP_LO: begin
          ln    <= rdata[WORD_W-1:0];
          ld    <= rdata[ENTRY_W-1:WORD_W];
          step  <= '0;
          state <= OP_MUL;
        end
        OP_MUL: begin
          prod <= mfull[WORD_W-1:0];
          step <= step + 2'd1;
          case (step)
            2'd1: rn <= prod;
            2'd2: begin
              if (cmd_q == CMD_ADD) begin
                rn <= rn + prod;
              end else if (cmd_q == CMD_SUB) begin
                rn <= rn - prod;
              end else begin
                rd    <= prod;
                state <= OP_WR;
              end
            end
            2'd3: begin
              rd    <= prod;
              state <= OP_WR;
            end
            default: rn <= rn;
          endcase
        end
        OP_WR: begin
          sp    <= sp_m1;
          state <= IDLE;
        end
        E_LD: begin
          d_r <= rdata[ENTRY_W-1:WORD_W];
          if (rdata[ENTRY_W-1:WORD_W] == '0) begin
            res_err <= ERR_ZERO;
            state   <= FIN;
          end else begin
            state <= E_Q;
          end
        end
        E_Q: begin
          if (div_done) begin
            res_ip <= div_q;
            r_r    <= div_r;
            a_r    <= div_r;
            b_r    <= d_r;
            state  <= E_G;
          end
        end
        E_G: begin
          state <= ($signed(b_r) > 0) ? E_GW : E_R1W;
        end
        E_GW: begin
          if (div_done) begin
            a_r   <= b_r;
            b_r   <= div_r;
            state <= E_G;
          end
        end
        E_R1W: begin
          if (div_done) begin
            res_fn <= div_q;
            state  <= E_R2;
          end
        end
        E_R2: state <= E_R2W;
        E_R2W: begin
          if (div_done) begin
            res_fd  <= div_q;
            res_err <= ERR_NONE;
            state   <= FIN;
          end
        end
        FIN: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_fd, res_fn, res_ip};
            m_tuser  <= {res_err, (res_fn != '0) && (res_fd != '0)};
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/rre_ram.sv -----
// ----------------------------------------------------------------------------
// rre_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rre_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rre_div.sv -----
// ----------------------------------------------------------------------------
// rre_div
// Signed truncating divider, one quotient bit per cycle. A zero divisor acts
// as one and division by minus one wraps, both with a zero remainder.
// ----------------------------------------------------------------------------
module rre_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rre_pkg::WORD_W-1:0] a,
  input  logic [rre_pkg::WORD_W-1:0] b,
  output logic                       done,
  output logic [rre_pkg::WORD_W-1:0] quo,
  output logic [rre_pkg::WORD_W-1:0] rem
);
  import rre_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX} state_t;

  state_t            state;
  logic [WORD_W-1:0] qr;
  logic [WORD_W-1:0] rr;
  logic [WORD_W-1:0] ub;
  logic [4:0]        cnt;
  logic              q_neg;
  logic              r_neg;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   trial;

  assign shifted = {rr, qr[WORD_W-1]};
  assign trial   = shifted - {1'b0, ub};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (b == '0) begin
              quo   <= a;
              rem   <= '0;
              done  <= 1'b1;
            end else if (b == '1) begin
              quo   <= '0 - a;
              rem   <= '0;
              done  <= 1'b1;
            end else begin
              qr    <= a[WORD_W-1] ? ('0 - a) : a;
              ub    <= b[WORD_W-1] ? ('0 - b) : b;
              rr    <= '0;
              cnt   <= '0;
              q_neg <= a[WORD_W-1] ^ b[WORD_W-1];
              r_neg <= a[WORD_W-1];
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          // restoring step: keep the trial difference when it did not borrow
          if (!trial[WORD_W]) begin
            rr <= trial[WORD_W-1:0];
            qr <= {qr[WORD_W-2:0], 1'b1};
          end else begin
            rr <= shifted[WORD_W-1:0];
            qr <= {qr[WORD_W-2:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          quo   <= q_neg ? ('0 - qr) : qr;
          rem   <= r_neg ? ('0 - rr) : rr;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
